// File: rtl/core/fdr_pkg.sv
package fdr_pkg;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	localparam int unsigned FRAME_WIDTH_RST = 640;
	localparam int unsigned FRAME_HEIGHT_RST = 480;

	localparam int PIXEL_W = 32;
	localparam int LEFT_W = 10;
	localparam int TOP_W = 10;
	localparam int RIGHT_W = 11;
	localparam int BOTTOM_W = 11;
	localparam int RUN_W = 16;
	localparam logic [RUN_W-1:0] RUN_MAX = '1;

	localparam int ENTRY_Q_DEPTH = 4;
	localparam int OUT_Q_DEPTH = 8;

	typedef struct packed {
		logic                rect_valid;
		logic [LEFT_W-1:0]   rect_left;
		logic [TOP_W-1:0]    rect_top;
		logic [RIGHT_W-1:0]  rect_right;
		logic [BOTTOM_W-1:0] rect_bottom;
		logic                frame_idle;
		logic [RUN_W-1:0]    standby_frames;
		logic [RUN_W-1:0]    change_frames;
	} rect_t;

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
		int unsigned r;
		if (v == 0) begin
			r = 1;
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// File: rtl/core/fdr_pixel_if.sv
interface fdr_pixel_if;
	logic                        valid;
	logic                        ready;
	logic [fdr_pkg::PIXEL_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

// File: rtl/core/fdr_rect_if.sv
interface fdr_rect_if;
	logic                         valid;
	logic                         ready;
	logic                         rect_valid;
	logic [fdr_pkg::LEFT_W-1:0]   rect_left;
	logic [fdr_pkg::TOP_W-1:0]    rect_top;
	logic [fdr_pkg::RIGHT_W-1:0]  rect_right;
	logic [fdr_pkg::BOTTOM_W-1:0] rect_bottom;
	logic                         frame_idle;
	logic [fdr_pkg::RUN_W-1:0]    standby_frames;
	logic [fdr_pkg::RUN_W-1:0]    change_frames;

	modport source (output valid, output rect_valid, output rect_left, output rect_top,
		output rect_right, output rect_bottom, output frame_idle, output standby_frames,
		output change_frames, input ready);
	modport sink (input valid, input rect_valid, input rect_left, input rect_top,
		input rect_right, input rect_bottom, input frame_idle, input standby_frames,
		input change_frames, output ready);
endinterface

// File: rtl/core/fdr_fifo.sv
module fdr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = store_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: rtl/core/fdr_front.sv
module fdr_front #(
	parameter int PIXEL_BITS = 32,
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	fdr_pixel_if.sink                         pixel_in,
	input  logic                              run,
	input  logic [$clog2(MAX_WIDTH + 1)-1:0]  width,
	input  logic [$clog2(MAX_HEIGHT + 1)-1:0] height,
	output logic                              push_valid,
	input  logic                              push_ready,
	output logic [PIXEL_BITS + $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT):0] push_data
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int WD_W  = $clog2(MAX_WIDTH + 1);
	localparam int HT_W  = $clog2(MAX_HEIGHT + 1);

	typedef struct packed {
		logic                  frame_end;
		logic [ROW_W-1:0]      row;
		logic [COL_W-1:0]      col;
		logic [PIXEL_BITS-1:0] pix;
	} entry_t;

	logic [COL_W-1:0] col_cnt_q;
	logic [ROW_W-1:0] row_cnt_q;
	logic [WD_W-1:0]  wm1;
	logic [HT_W-1:0]  hm1;
	logic             col_last;
	logic             row_last;
	logic             accept;
	entry_t           entry;

	assign wm1      = width - 1'b1;
	assign hm1      = height - 1'b1;
	assign col_last = (WD_W'(col_cnt_q) >= wm1);
	assign row_last = (HT_W'(row_cnt_q) >= hm1);

	assign pixel_in.ready = run && push_ready;
	assign push_valid     = run && pixel_in.valid;
	assign accept         = pixel_in.valid && pixel_in.ready;

	always_comb begin
		entry.pix       = pixel_in.pixel[PIXEL_BITS-1:0];
		entry.col       = (WD_W'(col_cnt_q) < width) ? col_cnt_q : COL_W'(wm1);
		entry.row       = (HT_W'(row_cnt_q) < height) ? row_cnt_q : ROW_W'(hm1);
		entry.frame_end = col_last && row_last;
	end

	assign push_data = entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_cnt_q <= '0;
				row_cnt_q <= row_last ? '0 : row_cnt_q + 1'b1;
			end else begin
				col_cnt_q <= col_cnt_q + 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/fdr_back.sv
module fdr_back #(
	parameter int PIXEL_BITS = 32,
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [$clog2(MAX_WIDTH + 1)-1:0] width,
	input  logic                             pop_valid,
	output logic                             pop_ready,
	input  logic [PIXEL_BITS + $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT):0] pop_data,
	output logic                             clear_done,
	fdr_rect_if.source                       rect_out
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int WD_W   = $clog2(MAX_WIDTH + 1);
	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int PROD_W = ROW_W + WD_W;
	localparam int RES_W  = $clog2(fdr_pkg::OUT_Q_DEPTH + 1);
	localparam int RECT_W = $bits(fdr_pkg::rect_t);

	typedef struct packed {
		logic                  frame_end;
		logic [ROW_W-1:0]      row;
		logic [COL_W-1:0]      col;
		logic [PIXEL_BITS-1:0] pix;
	} entry_t;

	entry_t                head;
	logic                  pop;
	logic [RES_W-1:0]      res_q;
	logic                  rect_take;

	logic                  vld_s1;
	logic                  vld_s2;
	logic                  vld_s3;
	entry_t                ent_s1;
	entry_t                ent_s2;
	entry_t                ent_s3;
	logic [ADDR_W-1:0]     addr_s2;
	logic [ADDR_W-1:0]     addr_s3;
	logic [PIXEL_BITS-1:0] rdata_s3;
	logic [PROD_W-1:0]     prod;

	logic [PIXEL_BITS-1:0] mem [DEPTH];
	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_wa;
	logic [PIXEL_BITS-1:0] mem_wd;

	logic                  clr_busy_q;
	logic [ADDR_W-1:0]     clr_addr_q;

	logic                  fwd_vld_q;
	logic [ADDR_W-1:0]     fwd_addr_q;
	logic [PIXEL_BITS-1:0] fwd_data_q;

	logic [PIXEL_BITS-1:0] old_pix;
	logic                  diff;
	logic                  fin;

	logic                  any_q;
	logic [COL_W-1:0]      min_col_q;
	logic [COL_W-1:0]      max_col_q;
	logic [ROW_W-1:0]      min_row_q;
	logic [ROW_W-1:0]      max_row_q;
	logic                  any_n;
	logic [COL_W-1:0]      min_col_n;
	logic [COL_W-1:0]      max_col_n;
	logic [ROW_W-1:0]      min_row_n;
	logic [ROW_W-1:0]      max_row_n;

	logic [fdr_pkg::RUN_W-1:0] idle_run_q;
	logic [fdr_pkg::RUN_W-1:0] change_run_q;
	logic [fdr_pkg::RUN_W-1:0] idle_run_n;
	logic [fdr_pkg::RUN_W-1:0] change_run_n;

	fdr_pkg::rect_t        res;
	logic                  out_room;
	logic                  out_valid;
	logic [RECT_W-1:0]     out_data;
	fdr_pkg::rect_t        out_rect;

	assign head       = entry_t'(pop_data);
	assign pop_ready  = !head.frame_end || (res_q < RES_W'(fdr_pkg::OUT_Q_DEPTH));
	assign pop        = pop_valid && pop_ready;
	assign clear_done = !clr_busy_q;
	assign rect_take  = rect_out.valid && rect_out.ready;

	assign prod = PROD_W'(ent_s1.row) * PROD_W'(width);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			res_q      <= '0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			fwd_vld_q  <= 1'b0;
		end else begin
			vld_s1    <= pop;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			fwd_vld_q <= diff;
			if ((pop && head.frame_end) && !rect_take) begin
				res_q <= res_q + 1'b1;
			end else if (!(pop && head.frame_end) && rect_take) begin
				res_q <= res_q - 1'b1;
			end
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		ent_s1     <= head;
		ent_s2     <= ent_s1;
		ent_s3     <= ent_s2;
		addr_s2    <= ADDR_W'(prod) + ADDR_W'(ent_s1.col);
		addr_s3    <= addr_s2;
		fwd_addr_q <= addr_s3;
		fwd_data_q <= ent_s3.pix;
	end

	assign mem_we = clr_busy_q || diff;
	assign mem_wa = clr_busy_q ? clr_addr_q : addr_s3;
	assign mem_wd = clr_busy_q ? '0 : ent_s3.pix;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_s3 <= mem[addr_s2];
	end

	assign old_pix = (fwd_vld_q && (fwd_addr_q == addr_s3)) ? fwd_data_q : rdata_s3;
	assign diff    = vld_s3 && (old_pix != ent_s3.pix);
	assign fin     = vld_s3 && ent_s3.frame_end;

	always_comb begin
		any_n     = any_q;
		min_col_n = min_col_q;
		max_col_n = max_col_q;
		min_row_n = min_row_q;
		max_row_n = max_row_q;
		if (diff) begin
			any_n = 1'b1;
			if (!any_q) begin
				min_col_n = ent_s3.col;
				max_col_n = ent_s3.col;
				min_row_n = ent_s3.row;
				max_row_n = ent_s3.row;
			end else begin
				if (ent_s3.col < min_col_q) min_col_n = ent_s3.col;
				if (ent_s3.col > max_col_q) max_col_n = ent_s3.col;
				if (ent_s3.row < min_row_q) min_row_n = ent_s3.row;
				if (ent_s3.row > max_row_q) max_row_n = ent_s3.row;
			end
		end
	end

	always_comb begin
		if (any_n) begin
			change_run_n = (change_run_q == fdr_pkg::RUN_MAX) ? change_run_q
				: change_run_q + 1'b1;
			idle_run_n   = '0;
		end else begin
			idle_run_n   = (idle_run_q == fdr_pkg::RUN_MAX) ? idle_run_q
				: idle_run_q + 1'b1;
			change_run_n = '0;
		end
		res.rect_valid     = any_n;
		res.rect_left      = any_n ? fdr_pkg::LEFT_W'(32'(min_col_n)) : '0;
		res.rect_top       = any_n ? fdr_pkg::TOP_W'(32'(min_row_n)) : '0;
		res.rect_right     = any_n ? fdr_pkg::RIGHT_W'(32'(max_col_n) + 32'd1) : '0;
		res.rect_bottom    = any_n ? fdr_pkg::BOTTOM_W'(32'(max_row_n) + 32'd1) : '0;
		res.frame_idle     = !any_n;
		res.standby_frames = idle_run_n;
		res.change_frames  = change_run_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q        <= 1'b0;
			min_col_q    <= '0;
			max_col_q    <= '0;
			min_row_q    <= '0;
			max_row_q    <= '0;
			idle_run_q   <= '0;
			change_run_q <= '0;
		end else if (fin) begin
			any_q        <= 1'b0;
			min_col_q    <= '0;
			max_col_q    <= '0;
			min_row_q    <= '0;
			max_row_q    <= '0;
			idle_run_q   <= idle_run_n;
			change_run_q <= change_run_n;
		end else begin
			any_q     <= any_n;
			min_col_q <= min_col_n;
			max_col_q <= max_col_n;
			min_row_q <= min_row_n;
			max_row_q <= max_row_n;
		end
	end

	fdr_fifo #(
		.WIDTH (RECT_W),
		.DEPTH (fdr_pkg::OUT_Q_DEPTH)
	) u_out_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fin && out_room),
		.push_ready (out_room),
		.push_data  (res),
		.pop_valid  (out_valid),
		.pop_ready  (rect_out.ready),
		.pop_data   (out_data)
	);

	assign out_rect                = fdr_pkg::rect_t'(out_data);
	assign rect_out.valid          = out_valid;
	assign rect_out.rect_valid     = out_rect.rect_valid;
	assign rect_out.rect_left      = out_rect.rect_left;
	assign rect_out.rect_top       = out_rect.rect_top;
	assign rect_out.rect_right     = out_rect.rect_right;
	assign rect_out.rect_bottom    = out_rect.rect_bottom;
	assign rect_out.frame_idle     = out_rect.frame_idle;
	assign rect_out.standby_frames = out_rect.standby_frames;
	assign rect_out.change_frames  = out_rect.change_frames;

endmodule

// File: rtl/core/frame_diff_dirty_rect_unit.sv
// Throughput: one pixel per cycle unless the queues or the clearing pass stall the input,
// with one frame-store read and at most one write per cycle. A frame's last pixel passes the
// entry queue, stages s1 to s3 and the result queue before the frame's result is valid.
// Reset: counters, bounding box and run counts clear, size returns to 640 x 480, then a
// clearing pass zeroes all MAX_WIDTH * MAX_HEIGHT words of the frame store with the pixel
// input held not ready; configuration writes are taken during the pass.
module frame_diff_dirty_rect_unit #(
	parameter int PIXEL_BITS = 32,
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	fdr_pixel_if.sink                       pixel_in,
	fdr_rect_if.source                      rect_out,
	input  logic                            cfg_we,
	input  logic [fdr_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [fdr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int WD_W    = $clog2(MAX_WIDTH + 1);
	localparam int HT_W    = $clog2(MAX_HEIGHT + 1);
	localparam int ENTRY_W = PIXEL_BITS + COL_W + ROW_W + 1;
	localparam logic [WD_W-1:0] WIDTH_RST =
		WD_W'(fdr_pkg::clamp_dim(fdr_pkg::FRAME_WIDTH_RST, MAX_WIDTH));
	localparam logic [HT_W-1:0] HEIGHT_RST =
		HT_W'(fdr_pkg::clamp_dim(fdr_pkg::FRAME_HEIGHT_RST, MAX_HEIGHT));

	logic [WD_W-1:0]    width_q;
	logic [HT_W-1:0]    height_q;
	logic               clear_done;
	logic               push_valid;
	logic               push_ready;
	logic [ENTRY_W-1:0] push_data;
	logic               pop_valid;
	logic               pop_ready;
	logic [ENTRY_W-1:0] pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			case (fdr_pkg::cfg_reg_t'(cfg_idx))
				fdr_pkg::REG_FRAME_WIDTH: begin
					width_q <= WD_W'(fdr_pkg::clamp_dim(32'(cfg_wdata), MAX_WIDTH));
				end
				fdr_pkg::REG_FRAME_HEIGHT: begin
					height_q <= HT_W'(fdr_pkg::clamp_dim(32'(cfg_wdata), MAX_HEIGHT));
				end
				default: begin
				end
			endcase
		end
	end

	fdr_front #(
		.PIXEL_BITS (PIXEL_BITS),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel_in   (pixel_in),
		.run        (clear_done),
		.width      (width_q),
		.height     (height_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	fdr_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (fdr_pkg::ENTRY_Q_DEPTH)
	) u_entry_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	fdr_back #(
		.PIXEL_BITS (PIXEL_BITS),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.width      (width_q),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.clear_done (clear_done),
		.rect_out   (rect_out)
	);

endmodule
